[sv/assert_macros.svh]
// Assertion macros used by dual_setpoint_button_panel_unit.
// Define NO_ASSERTIONS to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checks prop at every rising edge of clk while rst is low.
`define DSPB_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks ante |=> cons at rising edges of clk, while rst is low.
`define DSPB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define DSPB_ASSERT(lbl, clk, rst, prop, msg)
`define DSPB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

[sv/dspb_pkg.sv]
package dspb_pkg;

   localparam int DEF_COUNT_WIDTH    = 16;
   localparam int DEF_SETPOINT_WIDTH = 10;

   // Widths of the configuration registers and of the write port.
   localparam int PRESS_WIDTH    = 16;
   localparam int HOLD_WIDTH     = 16;
   localparam int SP_MAX_WIDTH   = 10;
   localparam int STEP_WIDTH     = 6;
   localparam int CSR_DATA_WIDTH = 16;
   localparam int CSR_IDX_WIDTH  = 2;

   // Reset values.
   localparam logic [PRESS_WIDTH-1:0]  PRESS_RESET  = 16'd20;
   localparam logic [HOLD_WIDTH-1:0]   HOLD_RESET   = 16'd65000;
   localparam logic [SP_MAX_WIDTH-1:0] SP_MAX_RESET = 10'd850;
   localparam logic [STEP_WIDTH-1:0]   STEP_RESET   = 6'd5;
   localparam int                      SP_RESET     = 600;

   // Button slots in the hold counter array.
   localparam int BTN_PICK_ONE = 0;
   localparam int BTN_PICK_TWO = 1;
   localparam int BTN_DOWN     = 2;
   localparam int BTN_UP       = 3;
   localparam int BTN_COUNT    = 4;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      REG_PRESS_COUNT  = 2'd0,
      REG_HOLD_COUNT   = 2'd1,
      REG_SETPOINT_MAX = 2'd2,
      REG_COARSE_STEP  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [PRESS_WIDTH-1:0]  press_count;
      logic [HOLD_WIDTH-1:0]   hold_count;
      logic [SP_MAX_WIDTH-1:0] setpoint_max;
      logic [STEP_WIDTH-1:0]   coarse_step;
   } cfg_type;

   typedef struct packed {
      logic up;
      logic down;
      logic pick_two;
      logic pick_one;
   } button_set_type;

endpackage

[sv/dspb_step.sv]
// Next state of the panel for one poll: hold counters, selection, heater
// enables and the chosen setpoint, applied in the order pick one, pick two,
// down, up.
module dspb_step
   import dspb_pkg::*;
#(
   parameter int COUNT_WIDTH    = DEF_COUNT_WIDTH,
   parameter int SETPOINT_WIDTH = DEF_SETPOINT_WIDTH
) (
   input  cfg_type                                 cfg,
   input  button_set_type                          buttons,
   input  logic [BTN_COUNT-1:0][COUNT_WIDTH-1:0]   count_q,
   input  logic                                    sel_q,
   input  logic [SETPOINT_WIDTH-1:0]               sp_one_q,
   input  logic [SETPOINT_WIDTH-1:0]               sp_two_q,
   input  logic [1:0]                              en_q,
   output logic [BTN_COUNT-1:0][COUNT_WIDTH-1:0]   count_n,
   output logic                                    sel_n,
   output logic [SETPOINT_WIDTH-1:0]               sp_one_n,
   output logic [SETPOINT_WIDTH-1:0]               sp_two_n,
   output logic [1:0]                              en_n
);

   // Compare width for counts against the 16-bit thresholds.
   localparam int CMP_W = (COUNT_WIDTH > PRESS_WIDTH) ? COUNT_WIDTH : PRESS_WIDTH;
   // Setpoint arithmetic width with one bit of headroom for the sums.
   localparam int SP_W  = ((SETPOINT_WIDTH > SP_MAX_WIDTH) ? SETPOINT_WIDTH
                                                           : SP_MAX_WIDTH) + 1;
   localparam logic [COUNT_WIDTH-1:0] COUNT_TOP = '1;

   logic [BTN_COUNT-1:0] pressed;
   logic [BTN_COUNT-1:0] at_press;
   logic [BTN_COUNT-1:0] at_hold;
   logic [BTN_COUNT-1:0] past_hold;
   logic [SP_W-1:0]      sp_max_x;
   logic [SP_W-1:0]      step_x;
   logic [SETPOINT_WIDTH-1:0] t_sel, t_fine_dn, t_coarse_dn, t_fine_up, t_coarse_up;

   assign pressed[BTN_PICK_ONE] = buttons.pick_one;
   assign pressed[BTN_PICK_TWO] = buttons.pick_two;
   assign pressed[BTN_DOWN]     = buttons.down;
   assign pressed[BTN_UP]       = buttons.up;

   assign sp_max_x = SP_W'(cfg.setpoint_max);
   assign step_x   = SP_W'(cfg.coarse_step);

   always_comb begin
      for (int i = 0; i < BTN_COUNT; i++) begin
         if (!pressed[i]) begin
            count_n[i] = '0;
         end else if (count_q[i] == COUNT_TOP) begin
            count_n[i] = count_q[i];
         end else begin
            count_n[i] = count_q[i] + 1'b1;
         end
         at_press[i]  = pressed[i] && (CMP_W'(count_n[i]) == CMP_W'(cfg.press_count));
         at_hold[i]   = pressed[i] && (CMP_W'(count_n[i]) == CMP_W'(cfg.hold_count));
         past_hold[i] = pressed[i] && (CMP_W'(count_n[i]) >  CMP_W'(cfg.hold_count));
      end
   end

   always_comb begin
      sel_n = sel_q;
      if (at_press[BTN_PICK_ONE]) begin
         sel_n = 1'b0;
      end
      if (at_press[BTN_PICK_TWO]) begin
         sel_n = 1'b1;
      end
   end

   assign en_n[0] = en_q[0] ^ at_hold[BTN_PICK_ONE];
   assign en_n[1] = en_q[1] ^ at_hold[BTN_PICK_TWO];

   assign t_sel = sel_n ? sp_two_q : sp_one_q;

   always_comb begin
      t_fine_dn = t_sel;
      if (at_press[BTN_DOWN] && (SP_W'(t_sel) > SP_W'(1))) begin
         t_fine_dn = t_sel - 1'b1;
      end

      t_coarse_dn = t_fine_dn;
      if (past_hold[BTN_DOWN] && (SP_W'(t_fine_dn) > (step_x + SP_W'(1)))) begin
         t_coarse_dn = SETPOINT_WIDTH'(SP_W'(t_fine_dn) - step_x);
      end

      t_fine_up = t_coarse_dn;
      if (at_press[BTN_UP] && (SP_W'(t_coarse_dn) < sp_max_x)) begin
         t_fine_up = t_coarse_dn + 1'b1;
      end

      t_coarse_up = t_fine_up;
      if (past_hold[BTN_UP] && ((SP_W'(t_fine_up) + step_x) < sp_max_x)) begin
         t_coarse_up = SETPOINT_WIDTH'(SP_W'(t_fine_up) + step_x);
      end
   end

   assign sp_one_n = sel_n ? sp_one_q : t_coarse_up;
   assign sp_two_n = sel_n ? t_coarse_up : sp_two_q;

endmodule

[sv/dual_setpoint_button_panel_unit.sv]
// Button panel for a two-heater station. Each transfer on the req_ channel
// is one poll of the four buttons (pick one, pick two, down, up) as pressed
// flags; each poll gives exactly one transfer on the rsp_ channel carrying
// both setpoints, the chosen iron and both heater enables as they stand
// after that poll. A new poll is taken on every clock while rsp_ does not
// stall. The poll is captured in an input register, and the whole update
// (hold counters, selection, enable toggles and the down-then-up setpoint
// chain) is then worked out combinationally into the panel state and the
// result register. The four csr_ registers (press count, hold count,
// setpoint maximum, coarse step) are always ready and should only be
// written while no poll is in flight.
`include "assert_macros.svh"

module dual_setpoint_button_panel_unit
   import dspb_pkg::*;
#(
   parameter int COUNT_WIDTH    = DEF_COUNT_WIDTH,
   parameter int SETPOINT_WIDTH = DEF_SETPOINT_WIDTH
) (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_down_pressed,
   input  logic                      req_up_pressed,
   input  logic                      req_pick_two_pressed,
   input  logic                      req_pick_one_pressed,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [SETPOINT_WIDTH-1:0] rsp_setpoint_one,
   output logic [SETPOINT_WIDTH-1:0] rsp_setpoint_two,
   output logic                      rsp_chosen_iron,
   output logic                      rsp_enable_one,
   output logic                      rsp_enable_two,

   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_wdata
);

   // Configuration registers.
   cfg_type cfg_ff, cfg_in;

   // Input stage: the captured poll.
   logic           in_valid_ff, in_valid_in;
   button_set_type in_btn_ff, in_btn_in;

   // Panel state.
   logic [BTN_COUNT-1:0][COUNT_WIDTH-1:0] count_ff, count_in;
   logic                                  sel_ff, sel_in;
   logic [SETPOINT_WIDTH-1:0]             sp_one_ff, sp_one_in;
   logic [SETPOINT_WIDTH-1:0]             sp_two_ff, sp_two_in;
   logic [1:0]                            en_ff, en_in;

   // Result register.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [SETPOINT_WIDTH-1:0] rsp_sp_one_ff, rsp_sp_two_ff;
   logic                      rsp_sel_ff;
   logic [1:0]                rsp_en_ff;

   logic req_take;
   logic advance;
   logic fire;

   // The result register can take a new value when it is empty or being
   // drained in this cycle; the captured poll is then processed.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // Configuration writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_PRESS_COUNT:  cfg_in.press_count  = csr_wdata[PRESS_WIDTH-1:0];
            REG_HOLD_COUNT:   cfg_in.hold_count   = csr_wdata[HOLD_WIDTH-1:0];
            REG_SETPOINT_MAX: cfg_in.setpoint_max = csr_wdata[SP_MAX_WIDTH-1:0];
            REG_COARSE_STEP:  cfg_in.coarse_step  = csr_wdata[STEP_WIDTH-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.press_count  <= PRESS_RESET;
         cfg_ff.hold_count   <= HOLD_RESET;
         cfg_ff.setpoint_max <= SP_MAX_RESET;
         cfg_ff.coarse_step  <= STEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input stage.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_btn_in   = in_btn_ff;
      if (req_take) begin
         in_valid_in        = 1'b1;
         in_btn_in.up       = req_up_pressed;
         in_btn_in.down     = req_down_pressed;
         in_btn_in.pick_two = req_pick_two_pressed;
         in_btn_in.pick_one = req_pick_one_pressed;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_btn_ff <= in_btn_in;
   end

   // One poll's worth of state update.
   logic [BTN_COUNT-1:0][COUNT_WIDTH-1:0] count_n;
   logic                                  sel_n;
   logic [SETPOINT_WIDTH-1:0]             sp_one_n, sp_two_n;
   logic [1:0]                            en_n;

   dspb_step #(
      .COUNT_WIDTH    (COUNT_WIDTH),
      .SETPOINT_WIDTH (SETPOINT_WIDTH)
   ) u_step (
      .cfg      (cfg_ff),
      .buttons  (in_btn_ff),
      .count_q  (count_ff),
      .sel_q    (sel_ff),
      .sp_one_q (sp_one_ff),
      .sp_two_q (sp_two_ff),
      .en_q     (en_ff),
      .count_n  (count_n),
      .sel_n    (sel_n),
      .sp_one_n (sp_one_n),
      .sp_two_n (sp_two_n),
      .en_n     (en_n)
   );

   assign count_in  = fire ? count_n  : count_ff;
   assign sel_in    = fire ? sel_n    : sel_ff;
   assign sp_one_in = fire ? sp_one_n : sp_one_ff;
   assign sp_two_in = fire ? sp_two_n : sp_two_ff;
   assign en_in     = fire ? en_n     : en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         sel_ff    <= 1'b0;
         sp_one_ff <= SETPOINT_WIDTH'(SP_RESET);
         sp_two_ff <= SETPOINT_WIDTH'(SP_RESET);
         en_ff     <= '0;
      end else begin
         count_ff  <= count_in;
         sel_ff    <= sel_in;
         sp_one_ff <= sp_one_in;
         sp_two_ff <= sp_two_in;
         en_ff     <= en_in;
      end
   end

   // Result register: holds its value until the transfer on rsp_ completes.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (fire) begin
         rsp_sp_one_ff <= sp_one_n;
         rsp_sp_two_ff <= sp_two_n;
         rsp_sel_ff    <= sel_n;
         rsp_en_ff     <= en_n;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_setpoint_one = rsp_sp_one_ff;
   assign rsp_setpoint_two = rsp_sp_two_ff;
   assign rsp_chosen_iron  = rsp_sel_ff;
   assign rsp_enable_one   = rsp_en_ff[0];
   assign rsp_enable_two   = rsp_en_ff[1];

   // A processed poll always leaves a result behind it.
   `DSPB_ASSERT_NEXT(a_fire_gives_result, clock, reset, fire, rsp_valid_ff, "processed poll left no result")

   // A result only appears after a captured poll was processed.
   `DSPB_ASSERT(a_result_has_source, clock, reset, $rose(rsp_valid_ff) |-> $past(in_valid_ff), "result without a captured poll")

   // Heater enables change only when a poll is processed.
   `DSPB_ASSERT(a_enable_only_on_poll, clock, reset, (!$past(reset) && !$past(fire)) |-> $stable(en_ff), "heater enable changed without a poll")

   // A released pick-one button leaves its hold counter cleared.
   `DSPB_ASSERT(a_release_clears_count, clock, reset, (!$past(reset) && $past(fire) && !$past(in_btn_ff.pick_one)) |-> (count_ff[BTN_PICK_ONE] == '0), "hold counter not cleared on release")

endmodule
